### rtl/lifeg_pkg.sv
// ----------------------------------------------------------------------------
// lifeg_pkg
// shared sizes, codes and reset values of the life generation core
// ----------------------------------------------------------------------------
`default_nettype none

package lifeg_pkg;

   localparam int GRID_COLUMNS = 32;
   localparam int GRID_ROWS    = 8;

   localparam int COL_AW    = $clog2(GRID_COLUMNS);
   localparam int COL_CNT_W = $clog2(GRID_COLUMNS + 1);
   localparam int RAM_DEPTH = 2 * GRID_COLUMNS;
   localparam int RAM_AW    = COL_AW + 1;
   localparam int POP_W     = $clog2(GRID_ROWS + 1);

   localparam int COLUMN_W   = 5;
   localparam int CELL_W     = 8;
   localparam int TOTAL_W    = 9;
   localparam int RAND_W     = 16;
   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 32;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 32;

   localparam logic [RAND_W-1:0] LFSR_TAPS       = 16'hB400;
   localparam logic [RAND_W-1:0] THRESHOLD_RESET = 16'd4588;
   localparam logic [RAND_W-1:0] SEED_RESET      = 16'd44257;

   localparam logic REQ_STEP = 1'b0;
   localparam logic REQ_LOAD = 1'b1;

   localparam logic REG_THRESHOLD = 1'b0;
   localparam logic REG_SEED      = 1'b1;

   typedef logic [GRID_ROWS-1:0] column_type;

endpackage

`default_nettype wire

### rtl/life_automaton_generation_core.sv
// ----------------------------------------------------------------------------
// life_automaton_generation_core
// b3/s23 life generation over a double-buffered column-major grid
// ----------------------------------------------------------------------------
// Both grids sit in one ram, the current one selected by the top address bit.
// A load word returns one result word. A step word sweeps the grid one column
// per cycle, when the result side does not stall, through the ram read port,
// keeping a window of three columns, and writes each new column into the other
// buffer. Grid clearing at reset is done by per-entry valid bits, so the core
// needs no clearing pass and is ready as soon as reset is released. Random
// births use a 16-bit Galois lfsr that steps once per draw.
`default_nettype none

module life_automaton_generation_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // req_tdata: mutate, load_column[4:0], load_cells[7:0], zero pad
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   input  wire logic [lifeg_pkg::REQ_DATA_W-1:0]    req_tdata,
   // req_tuser: req_type
   input  wire logic                                req_tuser,
   // rsp_tdata: column_index[4:0], alive_cells[7:0], draw_mask[7:0],
   // total_alive[8:0], zero pad
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   output      logic [lifeg_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output      logic                                rsp_tlast,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [lifeg_pkg::CSR_AW-1:0]        csr_paddr,
   input  wire logic [lifeg_pkg::CSR_DW-1:0]        csr_pwdata,
   output      logic [lifeg_pkg::CSR_DW-1:0]        csr_prdata,
   output      logic                                csr_pready
);

   typedef enum logic {ST_IDLE, ST_SWEEP} state_type;

   localparam int ROWS = lifeg_pkg::GRID_ROWS;
   localparam logic [lifeg_pkg::COL_CNT_W-1:0] COL_END =
      lifeg_pkg::COL_CNT_W'(lifeg_pkg::GRID_COLUMNS);

   state_type                             state_ff, state_in;
   logic                                  first_cur_ff, first_cur_in;
   logic [lifeg_pkg::RAND_W-1:0]          lfsr_ff, lfsr_in;
   logic [lifeg_pkg::RAND_W-1:0]          thresh_ff, thresh_in;
   logic [lifeg_pkg::RAND_W-1:0]          seed_ff, seed_in;
   logic                                  mutate_ff, mutate_in;
   logic [lifeg_pkg::COL_CNT_W-1:0]       rd_cnt_ff, rd_cnt_in;
   logic [lifeg_pkg::COL_CNT_W-1:0]       cons_ff, cons_in;
   logic                                  rvld_ff, rvld_in;
   logic                                  rd_ent_ff, rd_ent_in;
   logic [lifeg_pkg::RAM_DEPTH-1:0]       valid_ff, valid_in;
   lifeg_pkg::column_type                 left_ff, left_in;
   lifeg_pkg::column_type                 mid_ff, mid_in;
   logic [lifeg_pkg::TOTAL_W-1:0]         total_ff, total_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [lifeg_pkg::COLUMN_W-1:0]        rsp_col_ff, rsp_col_in;
   logic [lifeg_pkg::CELL_W-1:0]          rsp_cells_ff, rsp_cells_in;
   logic [lifeg_pkg::CELL_W-1:0]          rsp_mask_ff, rsp_mask_in;
   logic [lifeg_pkg::TOTAL_W-1:0]         rsp_total_ff, rsp_total_in;
   logic                                  rsp_last_ff, rsp_last_in;

   logic                                  ram_wr_en, ram_rd_en;
   logic [lifeg_pkg::RAM_AW-1:0]          ram_wr_addr, ram_rd_addr;
   lifeg_pkg::column_type                 ram_wr_data, ram_rd_data;

   logic                                  req_type;
   logic                                  req_mutate;
   logic [lifeg_pkg::COLUMN_W-1:0]        req_column;
   logic [lifeg_pkg::CELL_W-1:0]          req_cells;
   logic                                  req_fire, out_free, csr_wr;
   logic                                  shift, emit, issue, done, load_ok;
   lifeg_pkg::column_type                 right_col, load_col, col_new, mask_new;
   logic [lifeg_pkg::COL_AW-1:0]          emit_col;
   logic [lifeg_pkg::POP_W-1:0]           pop;
   logic [lifeg_pkg::TOTAL_W-1:0]         total_sum;
   logic [lifeg_pkg::RAND_W-1:0]          lfsr_step;

   assign req_type   = req_tuser;
   assign req_mutate = req_tdata[0];
   assign req_column = req_tdata[5:1];
   assign req_cells  = req_tdata[13:6];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      csr_prdata = '0;
      case (csr_paddr[2])
         lifeg_pkg::REG_THRESHOLD: csr_prdata = lifeg_pkg::CSR_DW'(thresh_ff);
         lifeg_pkg::REG_SEED:      csr_prdata = lifeg_pkg::CSR_DW'(seed_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   // sweep window control
   assign shift = (state_ff == ST_SWEEP) && (cons_ff != COL_END) && rvld_ff &&
                  ((cons_ff == '0) || out_free);
   assign emit  = (state_ff == ST_SWEEP) && (cons_ff != '0) && out_free &&
                  ((cons_ff == COL_END) || rvld_ff);
   assign done  = emit && (cons_ff == COL_END);
   assign issue = (state_ff == ST_SWEEP) && (rd_cnt_ff != COL_END) &&
                  (!rvld_ff || shift);

   assign right_col = (cons_ff == COL_END || !rd_ent_ff) ? '0 : ram_rd_data;
   assign emit_col  = lifeg_pkg::COL_AW'(cons_ff - 1'b1);

   assign load_ok  = ({1'b0, req_column} < (lifeg_pkg::COLUMN_W + 1)'(lifeg_pkg::GRID_COLUMNS));
   assign load_col = load_ok ? ROWS'(req_cells) : '0;

   // next generation of the middle column
   always_comb begin
      logic [ROWS+1:0] lp, mp, rp;
      logic [3:0]      n;
      logic            now, nxt;
      logic [lifeg_pkg::RAND_W-1:0] s;
      lp = {1'b0, left_ff, 1'b0};
      mp = {1'b0, mid_ff, 1'b0};
      rp = {1'b0, right_col, 1'b0};
      s = lfsr_ff;
      col_new  = '0;
      mask_new = '0;
      pop      = '0;
      for (int y = 0; y < ROWS; y++) begin
         n = 4'(lp[y]) + 4'(lp[y+1]) + 4'(lp[y+2]) + 4'(mp[y]) + 4'(mp[y+2]) +
             4'(rp[y]) + 4'(rp[y+1]) + 4'(rp[y+2]);
         now = mp[y+1];
         if (now) begin
            nxt = (n == 4'd2) || (n == 4'd3);
         end else if (n == 4'd3) begin
            nxt = 1'b1;
         end else if (n < 4'd3 && mutate_ff) begin
            s = s[0] ? ((s >> 1) ^ lifeg_pkg::LFSR_TAPS) : (s >> 1);
            nxt = s < thresh_ff;
         end else begin
            nxt = 1'b0;
         end
         col_new[y]  = nxt;
         mask_new[y] = (nxt != now) && (!nxt || n == 4'd3);
         pop = pop + lifeg_pkg::POP_W'(nxt);
      end
      lfsr_step = s;
   end

   assign total_sum = total_ff + lifeg_pkg::TOTAL_W'(pop);

   // ram ports
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = {first_cur_ff, emit_col};
      ram_wr_data = col_new;
      if (emit) begin
         ram_wr_en = 1'b1;
      end else if (req_fire && req_type == lifeg_pkg::REQ_LOAD && load_ok) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = {!first_cur_ff, lifeg_pkg::COL_AW'(req_column)};
         ram_wr_data = load_col;
      end
   end

   assign ram_rd_en   = issue;
   assign ram_rd_addr = {!first_cur_ff, lifeg_pkg::COL_AW'(rd_cnt_ff)};

   always_comb begin
      state_in     = state_ff;
      first_cur_in = first_cur_ff;
      lfsr_in      = lfsr_ff;
      thresh_in    = thresh_ff;
      seed_in      = seed_ff;
      mutate_in    = mutate_ff;
      rd_cnt_in    = rd_cnt_ff;
      cons_in      = cons_ff;
      rvld_in      = rvld_ff;
      rd_ent_in    = rd_ent_ff;
      valid_in     = valid_ff;
      left_in      = left_ff;
      mid_in       = mid_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_cells_in = rsp_cells_ff;
      rsp_mask_in  = rsp_mask_ff;
      rsp_total_in = rsp_total_ff;
      rsp_last_in  = rsp_last_ff;

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (ram_wr_en) begin
         valid_in[ram_wr_addr] = 1'b1;
      end
      if (issue) begin
         rd_cnt_in = rd_cnt_ff + 1'b1;
         rd_ent_in = valid_ff[ram_rd_addr];
         rvld_in   = 1'b1;
      end else if (shift) begin
         rvld_in = 1'b0;
      end
      if (shift) begin
         left_in = mid_ff;
         mid_in  = right_col;
         cons_in = cons_ff + 1'b1;
      end
      if (emit) begin
         lfsr_in      = lfsr_step;
         total_in     = total_sum;
         rsp_valid_in = 1'b1;
         rsp_col_in   = lifeg_pkg::COLUMN_W'(emit_col);
         rsp_cells_in = lifeg_pkg::CELL_W'(col_new);
         rsp_mask_in  = lifeg_pkg::CELL_W'(mask_new);
         rsp_total_in = done ? total_sum : '0;
         rsp_last_in  = done;
      end
      if (done) begin
         state_in     = ST_IDLE;
         first_cur_in = !first_cur_ff;
      end

      if (req_fire) begin
         case (req_type)
            lifeg_pkg::REQ_STEP: begin
               state_in  = ST_SWEEP;
               mutate_in = req_mutate;
               rd_cnt_in = '0;
               cons_in   = '0;
               total_in  = '0;
               left_in   = '0;
               mid_in    = '0;
            end
            lifeg_pkg::REQ_LOAD: begin
               rsp_valid_in = 1'b1;
               rsp_col_in   = req_column;
               rsp_cells_in = lifeg_pkg::CELL_W'(load_col);
               rsp_mask_in  = '0;
               rsp_total_in = '0;
               rsp_last_in  = 1'b1;
            end
            default: begin
               state_in = state_ff;
            end
         endcase
      end

      if (csr_wr) begin
         case (csr_paddr[2])
            lifeg_pkg::REG_THRESHOLD: begin
               thresh_in = csr_pwdata[lifeg_pkg::RAND_W-1:0];
            end
            lifeg_pkg::REG_SEED: begin
               seed_in = csr_pwdata[lifeg_pkg::RAND_W-1:0];
               lfsr_in = (csr_pwdata[lifeg_pkg::RAND_W-1:0] == '0) ?
                         lifeg_pkg::RAND_W'(1) : csr_pwdata[lifeg_pkg::RAND_W-1:0];
            end
            default: begin
               seed_in = seed_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         first_cur_ff <= 1'b1;
         lfsr_ff      <= lifeg_pkg::SEED_RESET;
         thresh_ff    <= lifeg_pkg::THRESHOLD_RESET;
         seed_ff      <= lifeg_pkg::SEED_RESET;
         rd_cnt_ff    <= '0;
         cons_ff      <= '0;
         rvld_ff      <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_cur_ff <= first_cur_in;
         lfsr_ff      <= lfsr_in;
         thresh_ff    <= thresh_in;
         seed_ff      <= seed_in;
         rd_cnt_ff    <= rd_cnt_in;
         cons_ff      <= cons_in;
         rvld_ff      <= rvld_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mutate_ff    <= mutate_in;
      rd_ent_ff    <= rd_ent_in;
      left_ff      <= left_in;
      mid_ff       <= mid_in;
      total_ff     <= total_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_cells_ff <= rsp_cells_in;
      rsp_mask_ff  <= rsp_mask_in;
      rsp_total_ff <= rsp_total_in;
      rsp_last_ff  <= rsp_last_in;
   end

   lifeg_ram #(
      .WIDTH(lifeg_pkg::GRID_ROWS),
      .DEPTH(lifeg_pkg::RAM_DEPTH)
   ) u_grid_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {2'b00, rsp_total_ff, rsp_mask_ff, rsp_cells_ff, rsp_col_ff};

   // the window never consumes a column that was not read
   a_cons_behind_reads: assert property (@(posedge clock) disable iff (reset)
      cons_ff <= rd_cnt_ff)
      else $error("window ran ahead of ram reads");

   // no read in flight outside a sweep
   a_idle_no_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !rvld_ff && !issue)
      else $error("ram read pending while idle");

   // lfsr never locks at zero
   a_lfsr_live: assert property (@(posedge clock) disable iff (reset)
      lfsr_ff != '0)
      else $error("lfsr reached zero");

   // an accepted word either starts a sweep or leaves a result
   a_accept_effect: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_SWEEP) || rsp_valid_ff)
      else $error("accepted word had no effect");

   // a finished sweep flips the current buffer
   a_done_flip: assert property (@(posedge clock) disable iff (reset)
      done |=> (first_cur_ff != $past(first_cur_ff)) && rsp_last_ff)
      else $error("buffer not swapped at end of sweep");

endmodule

`default_nettype wire

### rtl/lifeg_ram.sv
// ----------------------------------------------------------------------------
// lifeg_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module lifeg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### dv/life_automaton_generation_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_automaton_generation_core_tb
// self-checking bench for the b3/s23 life generation core
// ----------------------------------------------------------------------------
// Loads grid columns and requests generations over the request stream, with
// and without random births, under several threshold and seed settings
// written through the register port. A scoreboard keeps its own copy of both
// grid buffers and of the lfsr, predicts every result word and checks the
// result stream field by field. Both streams idle at random, and the result
// side holds off once for long enough to back the core up.
// ----------------------------------------------------------------------------

module life_automaton_generation_core_tb;
   import lifeg_pkg::*;

   localparam int IDLE_LIMIT  = 4000;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASE_WORDS = 90;
   localparam int PHASES      = 5;

   typedef struct packed {
      logic [COLUMN_W-1:0] column_index;
      logic [CELL_W-1:0]   alive_cells;
      logic [CELL_W-1:0]   draw_mask;
      logic [TOTAL_W-1:0]  total_alive;
      logic                is_last;
   } column_result;

   class generation_tracker;
      column_type        grids [2][GRID_COLUMNS];
      int                current_bank;
      logic [RAND_W-1:0] lfsr_state;
      logic [RAND_W-1:0] birth_threshold;
      column_result      expected_columns [$];
      int                mismatches;
      int                loads;
      int                generations;
      int                mutating_generations;
      int                random_births;
      int                words_checked;
      int                register_writes;

      function new();
         foreach (grids[b, x]) grids[b][x] = '0;
         current_bank    = 0;
         birth_threshold = THRESHOLD_RESET;
         lfsr_state      = SEED_RESET;
      endfunction

      function void set_register(logic index, logic [RAND_W-1:0] value);
         register_writes++;
         if (index == REG_THRESHOLD) begin
            birth_threshold = value;
         end else begin
            lfsr_state = (value == '0) ? RAND_W'(1) : value;
         end
      endfunction

      function bit cell_at(int x, int y);
         if (x < 0 || x >= GRID_COLUMNS || y < 0 || y >= GRID_ROWS) return 1'b0;
         return grids[current_bank][x][y];
      endfunction

      function logic [RAND_W-1:0] draw_random();
         if (lfsr_state[0]) begin
            lfsr_state = (lfsr_state >> 1) ^ LFSR_TAPS;
         end else begin
            lfsr_state = lfsr_state >> 1;
         end
         return lfsr_state;
      endfunction

      function void note_request(logic kind, logic mutate, logic [COLUMN_W-1:0] column,
                                 logic [CELL_W-1:0] cells);
         column_result r;
         int           x, y, dx, dy, n, total, fresh_bank;
         bit           now_alive, next_alive;
         column_type   col, mask;
         r = '0;
         if (kind == REQ_LOAD) begin
            loads++;
            r.column_index = column;
            r.is_last      = 1'b1;
            if (column < GRID_COLUMNS) begin
               grids[current_bank][column] = cells[GRID_ROWS-1:0];
               r.alive_cells = cells[GRID_ROWS-1:0];
            end
            expected_columns.push_back(r);
            return;
         end
         generations++;
         if (mutate) mutating_generations++;
         fresh_bank = 1 - current_bank;
         total = 0;
         for (x = 0; x < GRID_COLUMNS; x++) begin
            col  = '0;
            mask = '0;
            for (y = 0; y < GRID_ROWS; y++) begin
               n = 0;
               for (dx = -1; dx <= 1; dx++)
                  for (dy = -1; dy <= 1; dy++)
                     if (dx != 0 || dy != 0) n += cell_at(x + dx, y + dy);
               now_alive = cell_at(x, y);
               if (now_alive) begin
                  next_alive = (n == 2 || n == 3);
               end else if (n == 3) begin
                  next_alive = 1'b1;
               end else if (n < 3 && mutate) begin
                  next_alive = (draw_random() < birth_threshold);
                  if (next_alive) random_births++;
               end else begin
                  next_alive = 1'b0;
               end
               if (next_alive) begin
                  col[y] = 1'b1;
                  total++;
               end
               if (next_alive != now_alive && (!next_alive || n == 3)) mask[y] = 1'b1;
            end
            grids[fresh_bank][x] = col;
            r.column_index = COLUMN_W'(x);
            r.alive_cells  = col;
            r.draw_mask    = mask;
            r.total_alive  = (x == GRID_COLUMNS - 1) ? TOTAL_W'(total) : '0;
            r.is_last      = (x == GRID_COLUMNS - 1);
            expected_columns.push_back(r);
         end
         current_bank = fresh_bank;
      endfunction

      function void check_response(logic [RSP_DATA_W-1:0] data, logic tlast);
         column_result got, want;
         got.column_index = data[COLUMN_W-1:0];
         got.alive_cells  = data[COLUMN_W +: CELL_W];
         got.draw_mask    = data[COLUMN_W + CELL_W +: CELL_W];
         got.total_alive  = data[COLUMN_W + 2 * CELL_W +: TOTAL_W];
         got.is_last      = tlast;
         words_checked++;
         if (expected_columns.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t unexpected word: column %0d cells %h mask %h total %0d last %b",
                        $time, got.column_index, got.alive_cells, got.draw_mask,
                        got.total_alive, got.is_last);
            return;
         end
         want = expected_columns.pop_front();
         if (got.column_index !== want.column_index || got.alive_cells !== want.alive_cells ||
             got.draw_mask !== want.draw_mask || got.total_alive !== want.total_alive ||
             got.is_last !== want.is_last) begin
            mismatches++;
            if (mismatches <= 10) begin
               $write("%0t mismatch: expected column %0d cells %h mask %h total %0d last %b",
                      $time, want.column_index, want.alive_cells, want.draw_mask,
                      want.total_alive, want.is_last);
               $display(", got column %0d cells %h mask %h total %0d last %b",
                        got.column_index, got.alive_cells, got.draw_mask,
                        got.total_alive, got.is_last);
            end
         end
      endfunction

      function void account_leftovers();
         if (expected_columns.size() != 0) begin
            $display("%0d expected words never arrived", expected_columns.size());
            mismatches += expected_columns.size();
         end
      endfunction
   endclass

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   // req_tdata: mutate, load_column[4:0], load_cells[7:0], zero pad
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   // req_tuser: req_type
   logic                  req_tuser   = REQ_STEP;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   // rsp_tdata: column_index[4:0], alive_cells[7:0], draw_mask[7:0], total_alive[8:0]
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0]     csr_paddr   = '0;
   logic [CSR_DW-1:0]     csr_pwdata  = '0;
   logic [CSR_DW-1:0]     csr_prdata;
   logic                  csr_pready;

   logic                  hold_off_request = 1'b0;
   int                    burst_left       = 0;
   int                    gap_max          = 6;
   int                    sink_cycle       = 0;
   int                    hold_left        = 0;
   bit                    hold_taken       = 1'b0;
   int                    idle_cycles      = 0;
   generation_tracker     tracker;

   life_automaton_generation_core uut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // result side: own stall pattern, plus one long hold-off on request
   always @(posedge clock) begin
      sink_cycle++;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (hold_off_request && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left  = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         case ((sink_cycle / 150) % 4)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2: rsp_tready <= ($urandom_range(0, 1) != 0);
            default: rsp_tready <= ((sink_cycle % 7) < 3);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tracker.check_response(rsp_tdata, rsp_tlast);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic offer_word(logic kind, logic mutate, logic [COLUMN_W-1:0] column,
                             logic [CELL_W-1:0] cells);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {{(REQ_DATA_W - 1 - COLUMN_W - CELL_W){1'b0}}, cells, column, mutate};
      do @(posedge clock); while (!req_tready);
      tracker.note_request(kind, mutate, column, cells);
      if (burst_left > 0) begin
         burst_left--;
      end else if (gap_max > 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, gap_max)) @(posedge clock);
         burst_left = $urandom_range(0, 15);
      end
   endtask

   task automatic settle_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (tracker.expected_columns.size() != 0);
   endtask

   task automatic program_registers(logic [RAND_W-1:0] threshold, logic [RAND_W-1:0] seed);
      logic [RAND_W-1:0] values [2];
      logic              register_index [2];
      values         = '{threshold, seed};
      register_index = '{REG_THRESHOLD, REG_SEED};
      foreach (values[i]) begin
         csr_psel    <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite  <= 1'b1;
         csr_paddr   <= {register_index[i], 2'b00};
         csr_pwdata  <= CSR_DW'(values[i]);
         @(posedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         tracker.set_register(register_index[i], values[i]);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   initial begin : stimulus
      int                phase;
      int                i;
      logic [CELL_W-1:0] cells;
      tracker = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty grid, edge columns full, a blinker and a glider
      offer_word(REQ_STEP, 1'b0, 5'd0, 8'h00);
      offer_word(REQ_LOAD, 1'b0, 5'd0, 8'hFF);
      offer_word(REQ_LOAD, 1'b1, 5'd31, 8'hFF);
      offer_word(REQ_LOAD, 1'b0, 5'd15, 8'h1C);
      offer_word(REQ_LOAD, 1'b1, 5'd1, 8'h00);
      offer_word(REQ_STEP, 1'b0, 5'd31, 8'hFF);
      offer_word(REQ_STEP, 1'b0, 5'd0, 8'h00);
      offer_word(REQ_LOAD, 1'b0, 5'd20, 8'h04);
      offer_word(REQ_LOAD, 1'b0, 5'd21, 8'h05);
      offer_word(REQ_LOAD, 1'b0, 5'd22, 8'h06);
      offer_word(REQ_STEP, 1'b0, 5'd0, 8'h00);
      offer_word(REQ_STEP, 1'b1, 5'd0, 8'h00);
      settle_results();
      // every sparse dead cell born, zero seed falls back to one
      program_registers(16'hFFFF, 16'h0000);
      offer_word(REQ_STEP, 1'b1, 5'd0, 8'h00);
      offer_word(REQ_STEP, 1'b1, 5'd0, 8'h00);
      settle_results();
      // no random births at all
      program_registers(16'h0000, 16'hFFFF);
      offer_word(REQ_LOAD, 1'b0, 5'd30, 8'h55);
      offer_word(REQ_LOAD, 1'b1, 5'd31, 8'hAA);
      offer_word(REQ_STEP, 1'b1, 5'd0, 8'h00);
      offer_word(REQ_STEP, 1'b0, 5'd0, 8'h00);
      settle_results();

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: program_registers(THRESHOLD_RESET, SEED_RESET);
            1: program_registers(16'hFFFF, 16'd1);
            2: program_registers(16'h0000, RAND_W'($urandom_range(1, 65535)));
            3: program_registers(RAND_W'($urandom_range(0, 65535)),
                                 RAND_W'($urandom_range(1, 65535)));
            default: program_registers(16'd12000, 16'h8000);
         endcase
         gap_max = (phase == 3) ? 0 : phase + 3;
         for (i = 0; i < PHASE_WORDS; i++) begin
            if (phase == 2 && i == 10) hold_off_request <= 1'b1;
            if ($urandom_range(0, 99) < 3) settle_results();
            if ($urandom_range(0, 99) < 22) begin
               offer_word(REQ_STEP, 1'($urandom_range(0, 1)), COLUMN_W'($urandom),
                          CELL_W'($urandom));
            end else begin
               cells = CELL_W'($urandom);
               case ($urandom_range(0, 2))
                  0: cells &= CELL_W'($urandom);
                  2: cells |= CELL_W'($urandom);
                  default: ;
               endcase
               offer_word(REQ_LOAD, 1'($urandom_range(0, 1)), COLUMN_W'($urandom), cells);
            end
         end
         settle_results();
      end

      repeat (3 * (GRID_COLUMNS + 2)) @(posedge clock);
      tracker.account_leftovers();
      $display("ran %0d column loads and %0d generations, %0d of them with random births",
               tracker.loads, tracker.generations, tracker.mutating_generations);
      $display("%0d cells born at random, %0d result words checked, %0d register writes",
               tracker.random_births, tracker.words_checked, tracker.register_writes);
      if (tracker.mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
